// ===== rtl/xfmix_pkg.sv =====
// ----------------------------------------------------------------------------
// xfmix_pkg
// Types, codes and constants shared by the crossfade mixer modules.
// ----------------------------------------------------------------------------
package xfmix_pkg;

	localparam int FRAME_BITS   = 24;
	localparam int MAX_CHANNELS = 8;
	localparam int CHAN_BITS    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_BITS     = $clog2(MAX_CHANNELS + 1);
	localparam int LEN_BITS     = 24;
	localparam int CMP_BITS     = (FRAME_BITS > LEN_BITS) ? FRAME_BITS : LEN_BITS;

	localparam int SAMPLE_BITS  = 16;
	localparam int PCT_BITS     = 7;
	localparam int MODE_BITS    = 3;
	localparam int CC_BITS      = 4;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] REG_MIX_MODE      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIX_PERCENT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_FRAMES  = 2'd3;

	localparam logic [MODE_BITS-1:0] MODE_EXP = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_LOG = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_SIG = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_AVG = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_ADD = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_SUB = 3'd5;

	localparam logic [PCT_BITS-1:0] PCT_FULL   = 7'd100;
	localparam logic [PCT_BITS-1:0] PCT_RESET  = 7'd100;
	localparam logic [CC_BITS-1:0]  CC_RESET   = 4'd2;
	localparam logic [LEN_BITS-1:0] LEN_RESET  = 24'd1;

	localparam logic [16:0] Q16_ONE     = 17'h10000;
	localparam logic [19:0] SIG_MID     = 20'd327680;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [31:0] Q24_ONE     = 32'h0100_0000;
	localparam logic [3:0]  TAYLOR_LAST = 4'd12;
	localparam logic [4:0]  NORM_TOP    = 5'd30;

	// ceil(2^30 / 100), exact floor division for operands below 2^23
	localparam logic [23:0] RECIP_100   = 24'd10737419;

	localparam int DVD_BITS      = 48;
	localparam int DSR_BITS      = 32;
	localparam int DCNT_BITS     = $clog2(DVD_BITS + 1);
	localparam int FIFO_DEPTH    = 2;
	localparam int FIFO_PTR      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		CLS_EXP,
		CLS_LOG,
		CLS_SIG,
		CLS_AVG,
		CLS_ADD,
		CLS_SUB,
		CLS_ZERO
	} cls_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_a;
		logic signed [SAMPLE_BITS-1:0] sample_b;
		cls_t                          cls;
		logic [PCT_BITS-1:0]           pct;
		logic [LEN_BITS-1:0]           frame;
		logic [LEN_BITS-1:0]           len;
	} item_t;

	typedef struct packed {
		logic                start;
		logic [DVD_BITS-1:0] dividend;
		logic [DSR_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DVD_BITS-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISP,
		ST_XDIV,
		ST_TMUL,
		ST_TDIV,
		ST_TEND,
		ST_ESQ,
		ST_FLNCH,
		ST_FDIV,
		ST_LNORM,
		ST_LSQ,
		ST_LLNCH,
		ST_LDIV,
		ST_CAP,
		ST_PDIV,
		ST_BL1,
		ST_BL2,
		ST_BL3,
		ST_AVG,
		ST_DONE
	} back_state_t;

endpackage

// ===== rtl/xfmix_in_if.sv =====
// ----------------------------------------------------------------------------
// xfmix_in_if
// Input sample pair channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface xfmix_in_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] sample_a;
	logic signed [15:0] sample_b;
	logic        partner_present;
	logic        start_of_clip;

	modport source (output valid, sample_a, sample_b, partner_present, start_of_clip,
		input ready);
	modport sink (input valid, sample_a, sample_b, partner_present, start_of_clip,
		output ready);
endinterface

// ===== rtl/xfmix_out_if.sv =====
// ----------------------------------------------------------------------------
// xfmix_out_if
// Mixed sample result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface xfmix_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] mixed_sample;
	logic        saturated;

	modport source (output valid, mixed_sample, saturated, input ready);
	modport sink (input valid, mixed_sample, saturated, output ready);
endinterface

// ===== rtl/xfmix_front.sv =====
// ----------------------------------------------------------------------------
// xfmix_front
// Takes input requests, tracks channel and frame position, classifies the
// work and pushes a self-contained item to the queue.
// ----------------------------------------------------------------------------
module xfmix_front (
	input  logic                              clk,
	input  logic                              arst_n,
	xfmix_in_if.sink                          in_ch,
	input  logic [xfmix_pkg::MODE_BITS-1:0]   mix_mode,
	input  logic [xfmix_pkg::PCT_BITS-1:0]    mix_percent,
	input  logic [xfmix_pkg::CC_BITS-1:0]     channel_count,
	input  logic [xfmix_pkg::LEN_BITS-1:0]    total_frames,
	output logic                              push_valid,
	output xfmix_pkg::item_t                  push_item,
	input  logic                              push_ready
);

	logic [xfmix_pkg::FRAME_BITS-1:0] frame_q;
	logic [xfmix_pkg::CHAN_BITS-1:0]  chan_q;

	logic [xfmix_pkg::FRAME_BITS-1:0] fi;
	logic [xfmix_pkg::CHAN_BITS-1:0]  ci;
	logic [xfmix_pkg::CNT_BITS-1:0]   chans;
	logic [xfmix_pkg::CNT_BITS-1:0]   ci_next;
	logic [xfmix_pkg::LEN_BITS-1:0]   n;
	logic [xfmix_pkg::CMP_BITS-1:0]   fi_ext;
	logic [xfmix_pkg::CMP_BITS-1:0]   n_ext;
	logic                             accept;
	xfmix_pkg::cls_t                  cls;

	assign accept     = in_ch.valid && push_ready;
	assign in_ch.ready = push_ready;
	assign push_valid = in_ch.valid;

	always_comb begin
		fi = in_ch.start_of_clip ? '0 : frame_q;
		ci = in_ch.start_of_clip ? '0 : chan_q;
		n  = (total_frames == '0) ? xfmix_pkg::LEN_BITS'(1) : total_frames;
		fi_ext = xfmix_pkg::CMP_BITS'(fi);
		n_ext  = xfmix_pkg::CMP_BITS'(n);
		if (channel_count == '0) begin
			chans = xfmix_pkg::CNT_BITS'(1);
		end else if (int'(channel_count) > xfmix_pkg::MAX_CHANNELS) begin
			chans = xfmix_pkg::CNT_BITS'(xfmix_pkg::MAX_CHANNELS);
		end else begin
			chans = xfmix_pkg::CNT_BITS'(channel_count);
		end
		ci_next = xfmix_pkg::CNT_BITS'(ci) + xfmix_pkg::CNT_BITS'(1);
	end

	always_comb begin
		case (mix_mode)
			xfmix_pkg::MODE_AVG: cls = xfmix_pkg::CLS_AVG;
			xfmix_pkg::MODE_ADD: cls = xfmix_pkg::CLS_ADD;
			xfmix_pkg::MODE_SUB: cls = xfmix_pkg::CLS_SUB;
			xfmix_pkg::MODE_LOG: cls = in_ch.partner_present ? xfmix_pkg::CLS_LOG
				: xfmix_pkg::CLS_ZERO;
			xfmix_pkg::MODE_SIG: cls = in_ch.partner_present ? xfmix_pkg::CLS_SIG
				: xfmix_pkg::CLS_ZERO;
			default:             cls = in_ch.partner_present ? xfmix_pkg::CLS_EXP
				: xfmix_pkg::CLS_ZERO;
		endcase
	end

	always_comb begin
		push_item.sample_a = in_ch.sample_a;
		push_item.sample_b = in_ch.sample_b;
		push_item.cls      = cls;
		push_item.pct      = (mix_percent > xfmix_pkg::PCT_FULL) ? xfmix_pkg::PCT_FULL
			: mix_percent;
		push_item.frame    = (fi_ext > n_ext) ? n : xfmix_pkg::LEN_BITS'(fi_ext);
		push_item.len      = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			chan_q  <= '0;
		end else if (accept) begin
			if (ci_next >= chans) begin
				chan_q <= '0;
				// frame count stops at the clip length and at its own maximum
				if (fi_ext < n_ext && fi != '1) begin
					frame_q <= fi + xfmix_pkg::FRAME_BITS'(1);
				end else begin
					frame_q <= fi;
				end
			end else begin
				chan_q  <= xfmix_pkg::CHAN_BITS'(ci_next);
				frame_q <= fi;
			end
		end
	end

endmodule

// ===== rtl/xfmix_fifo.sv =====
// ----------------------------------------------------------------------------
// xfmix_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module xfmix_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  xfmix_pkg::item_t push_item,
	output logic             push_ready,
	output logic             pop_valid,
	output xfmix_pkg::item_t pop_item,
	input  logic             pop_ready
);

	xfmix_pkg::item_t                    slot_q [xfmix_pkg::FIFO_DEPTH];
	logic [xfmix_pkg::FIFO_PTR-1:0]      wr_q;
	logic [xfmix_pkg::FIFO_PTR-1:0]      rd_q;
	logic [xfmix_pkg::FIFO_CNT_BITS-1:0] cnt_q;
	logic                                push;
	logic                                pop;

	assign push_ready = (cnt_q != xfmix_pkg::FIFO_CNT_BITS'(xfmix_pkg::FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (int'(wr_q) == xfmix_pkg::FIFO_DEPTH - 1) ? '0
					: wr_q + xfmix_pkg::FIFO_PTR'(1);
			end
			if (pop) begin
				rd_q <= (int'(rd_q) == xfmix_pkg::FIFO_DEPTH - 1) ? '0
					: rd_q + xfmix_pkg::FIFO_PTR'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + xfmix_pkg::FIFO_CNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - xfmix_pkg::FIFO_CNT_BITS'(1);
			end
		end
	end

endmodule

// ===== rtl/xfmix_div.sv =====
// ----------------------------------------------------------------------------
// xfmix_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xfmix_div (
	input  logic                clk,
	input  logic                arst_n,
	input  xfmix_pkg::div_req_t req,
	output xfmix_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [xfmix_pkg::DCNT_BITS-1:0]     cnt_q;
	logic [xfmix_pkg::DVD_BITS-1:0]      dvd_q;
	logic [xfmix_pkg::DSR_BITS-1:0]      dsr_q;
	logic [xfmix_pkg::DSR_BITS-1:0]      rem_q;
	logic [xfmix_pkg::DSR_BITS:0]        rem_sh;
	logic                                ge;

	assign rem_sh = {rem_q, dvd_q[xfmix_pkg::DVD_BITS-1]};
	assign ge     = (rem_sh >= {1'b0, dsr_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops out
			rem_q <= ge ? xfmix_pkg::DSR_BITS'(rem_sh - {1'b0, dsr_q})
				: rem_sh[xfmix_pkg::DSR_BITS-1:0];
			dvd_q <= {dvd_q[xfmix_pkg::DVD_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= xfmix_pkg::DCNT_BITS'(xfmix_pkg::DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - xfmix_pkg::DCNT_BITS'(1);
				if (cnt_q == xfmix_pkg::DCNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/xfmix_back.sv =====
// ----------------------------------------------------------------------------
// xfmix_back
// Sequencer that evaluates the blend curves and mixing modes for one item
// at a time and holds the result in an output register.
// ----------------------------------------------------------------------------
module xfmix_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  xfmix_pkg::item_t    pop_item,
	output logic                pop_ready,
	output xfmix_pkg::div_req_t div_req,
	input  xfmix_pkg::div_rsp_t div_rsp,
	xfmix_out_if.source         out_ch
);

	xfmix_pkg::back_state_t state_q;
	xfmix_pkg::back_state_t state_d;

	xfmix_pkg::item_t    it_q;
	logic [30:0]         z_q;
	logic [30:0]         term_q;
	logic [32:0]         sum_q;
	logic [3:0]          k_q;
	logic                pos_q;
	logic [31:0]         e_q;
	logic [1:0]          sq_q;
	logic [30:0]         lm_q;
	logic [4:0]          lp_q;
	logic [15:0]         lfrac_q;
	logic [3:0]          lb_q;
	logic                lsel_q;
	logic [20:0]         l1_q;
	logic [32:0]         fr_q;
	logic [16:0]         f_q;
	logic signed [33:0]  acc_q;
	logic                neg_q;
	logic [22:0]         mag_q;
	logic [22:0]         pf_q;
	logic [15:0]         res_q;
	logic                sat_q;

	logic                ovalid_q;
	logic [15:0]         omix_q;
	logic                osat_q;
	logic                out_free;

	logic [61:0]         prod;
	logic [63:0]         esq;
	logic [61:0]         lsq;
	logic [31:0]         lsq_s;
	logic [16:0]         fcap;
	logic [16:0]         x;
	logic [19:0]         tx;
	logic [19:0]         u;
	logic signed [23:0]  a_w;
	logic signed [23:0]  b_w;
	logic signed [23:0]  wa_w;
	logic signed [23:0]  wb_w;
	logic signed [23:0]  num;
	logic [22:0]         num_mag;
	logic [46:0]         pf_prod;
	logic [46:0]         avg_prod;
	logic signed [33:0]  a34;
	logic signed [33:0]  b34;
	logic signed [33:0]  wa34;
	logic signed [33:0]  wb34;
	logic signed [33:0]  acc_adj;
	logic signed [16:0]  s17;
	logic                s_ovf;
	logic [15:0]         frac_new;

	assign out_free = !ovalid_q || out_ch.ready;

	// datapath helpers
	always_comb begin
		prod  = 62'(term_q) * 62'(z_q);
		esq   = 64'(e_q) * 64'(e_q);
		lsq   = 62'(lm_q) * 62'(lm_q);
		lsq_s = lsq[61:30];
		fcap  = (fr_q > 33'(xfmix_pkg::Q16_ONE)) ? xfmix_pkg::Q16_ONE : fr_q[16:0];
		x     = div_rsp.quotient[16:0];
		tx    = 20'(x) * 20'd10;
		u     = (tx >= xfmix_pkg::SIG_MID) ? tx - xfmix_pkg::SIG_MID
			: xfmix_pkg::SIG_MID - tx;
		a_w   = 24'(it_q.sample_a);
		b_w   = 24'(it_q.sample_b);
		wa_w  = 24'(xfmix_pkg::PCT_FULL - it_q.pct);
		wb_w  = 24'(it_q.pct);
		num   = a_w * wa_w + b_w * wb_w;
		num_mag = num[23] ? 23'(-num) : num[22:0];
		// divide by one hundred through a reciprocal multiply
		pf_prod  = 47'(pf_q) * 47'(xfmix_pkg::RECIP_100);
		avg_prod = 47'(mag_q) * 47'(xfmix_pkg::RECIP_100);
		a34   = 34'(it_q.sample_a);
		b34   = 34'(it_q.sample_b);
		wa34  = 34'(xfmix_pkg::Q16_ONE - f_q);
		wb34  = 34'(f_q);
		acc_adj = acc_q + (acc_q[33] ? 34'sd65535 : 34'sd0);
		s17   = (it_q.cls == xfmix_pkg::CLS_ADD) ? 17'(it_q.sample_a) + 17'(it_q.sample_b)
			: 17'(it_q.sample_a) - 17'(it_q.sample_b);
		s_ovf = s17[16] != s17[15];
		frac_new = lfrac_q;
		frac_new[lb_q] = lsq_s[31];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			xfmix_pkg::ST_IDLE: if (pop_valid) state_d = xfmix_pkg::ST_DISP;
			xfmix_pkg::ST_DISP: begin
				case (it_q.cls)
					xfmix_pkg::CLS_ADD, xfmix_pkg::CLS_SUB,
					xfmix_pkg::CLS_ZERO: state_d = xfmix_pkg::ST_DONE;
					xfmix_pkg::CLS_AVG: state_d = xfmix_pkg::ST_AVG;
					xfmix_pkg::CLS_LOG: state_d = xfmix_pkg::ST_LNORM;
					default: state_d = xfmix_pkg::ST_XDIV;
				endcase
			end
			xfmix_pkg::ST_XDIV: if (div_rsp.done) state_d = xfmix_pkg::ST_TMUL;
			xfmix_pkg::ST_TMUL: state_d = xfmix_pkg::ST_TDIV;
			xfmix_pkg::ST_TDIV: begin
				if (div_rsp.done) begin
					state_d = (k_q == xfmix_pkg::TAYLOR_LAST) ? xfmix_pkg::ST_TEND
						: xfmix_pkg::ST_TMUL;
				end
			end
			xfmix_pkg::ST_TEND: state_d = (it_q.cls == xfmix_pkg::CLS_SIG) ? xfmix_pkg::ST_ESQ
				: xfmix_pkg::ST_CAP;
			xfmix_pkg::ST_ESQ: if (sq_q == 2'd2) state_d = xfmix_pkg::ST_FLNCH;
			xfmix_pkg::ST_FLNCH: state_d = xfmix_pkg::ST_FDIV;
			xfmix_pkg::ST_FDIV: if (div_rsp.done) state_d = xfmix_pkg::ST_CAP;
			xfmix_pkg::ST_LNORM: if (lm_q[30]) state_d = xfmix_pkg::ST_LSQ;
			xfmix_pkg::ST_LSQ: begin
				if (lb_q == '0) begin
					state_d = lsel_q ? xfmix_pkg::ST_LLNCH : xfmix_pkg::ST_LNORM;
				end
			end
			xfmix_pkg::ST_LLNCH: state_d = xfmix_pkg::ST_LDIV;
			xfmix_pkg::ST_LDIV: if (div_rsp.done) state_d = xfmix_pkg::ST_CAP;
			xfmix_pkg::ST_CAP: state_d = xfmix_pkg::ST_PDIV;
			xfmix_pkg::ST_PDIV: state_d = xfmix_pkg::ST_BL1;
			xfmix_pkg::ST_BL1: state_d = xfmix_pkg::ST_BL2;
			xfmix_pkg::ST_BL2: state_d = xfmix_pkg::ST_BL3;
			xfmix_pkg::ST_BL3: state_d = xfmix_pkg::ST_DONE;
			xfmix_pkg::ST_AVG: state_d = xfmix_pkg::ST_DONE;
			xfmix_pkg::ST_DONE: if (out_free) state_d = xfmix_pkg::ST_IDLE;
			default: state_d = xfmix_pkg::ST_IDLE;
		endcase
	end

	// outputs: queue pop and divider launches
	always_comb begin
		pop_ready        = (state_q == xfmix_pkg::ST_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			xfmix_pkg::ST_DISP: begin
				if (it_q.cls == xfmix_pkg::CLS_EXP || it_q.cls == xfmix_pkg::CLS_SIG) begin
					div_req.start    = 1'b1;
					div_req.dividend = xfmix_pkg::DVD_BITS'({it_q.frame, 16'h0000});
					div_req.divisor  = xfmix_pkg::DSR_BITS'(it_q.len);
				end
			end
			xfmix_pkg::ST_TMUL: begin
				div_req.start    = 1'b1;
				div_req.dividend = xfmix_pkg::DVD_BITS'(prod[61:30]);
				div_req.divisor  = xfmix_pkg::DSR_BITS'(k_q);
			end
			xfmix_pkg::ST_FLNCH: begin
				div_req.start    = 1'b1;
				div_req.dividend = pos_q ? {e_q, 16'h0000}
					: xfmix_pkg::DVD_BITS'({xfmix_pkg::Q24_ONE, 16'h0000});
				div_req.divisor  = e_q + xfmix_pkg::Q24_ONE;
			end
			xfmix_pkg::ST_LLNCH: begin
				div_req.start    = 1'b1;
				div_req.dividend = xfmix_pkg::DVD_BITS'({l1_q, 16'h0000});
				div_req.divisor  = xfmix_pkg::DSR_BITS'({lp_q, lfrac_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xfmix_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			xfmix_pkg::ST_IDLE: begin
				it_q <= pop_item;
			end
			xfmix_pkg::ST_DISP: begin
				neg_q  <= num[23];
				mag_q  <= num_mag;
				lm_q   <= 31'(it_q.frame) + 31'd1;
				lp_q   <= xfmix_pkg::NORM_TOP;
				lsel_q <= 1'b0;
				if (it_q.cls == xfmix_pkg::CLS_ADD || it_q.cls == xfmix_pkg::CLS_SUB) begin
					sat_q <= s_ovf;
					res_q <= s_ovf ? (s17[16] ? 16'h8000 : 16'h7fff) : s17[15:0];
				end else begin
					res_q <= '0;
					sat_q <= 1'b0;
				end
			end
			xfmix_pkg::ST_XDIV: begin
				k_q <= 4'd2;
				if (it_q.cls == xfmix_pkg::CLS_SIG) begin
					pos_q  <= (tx >= xfmix_pkg::SIG_MID);
					z_q    <= 31'({u, 11'h000});
					term_q <= 31'({u, 11'h000});
					sum_q  <= 33'(xfmix_pkg::Q30_ONE) + 33'({u, 11'h000});
				end else begin
					z_q    <= 31'({x, 14'h0000});
					term_q <= 31'({x, 14'h0000});
					sum_q  <= 33'({x, 14'h0000});
				end
			end
			xfmix_pkg::ST_TDIV: begin
				if (div_rsp.done) begin
					term_q <= div_rsp.quotient[30:0];
					sum_q  <= sum_q + 33'(div_rsp.quotient[30:0]);
					k_q    <= k_q + 4'd1;
				end
			end
			xfmix_pkg::ST_TEND: begin
				fr_q <= 33'(sum_q[32:14]);
				e_q  <= 32'(sum_q[32:6]);
				sq_q <= '0;
			end
			xfmix_pkg::ST_ESQ: begin
				e_q  <= esq[55:24];
				sq_q <= sq_q + 2'd1;
			end
			xfmix_pkg::ST_FDIV, xfmix_pkg::ST_LDIV: begin
				if (div_rsp.done) begin
					fr_q <= div_rsp.quotient[32:0];
				end
			end
			xfmix_pkg::ST_LNORM: begin
				lfrac_q <= '0;
				lb_q    <= 4'd15;
				if (!lm_q[30]) begin
					lm_q <= {lm_q[29:0], 1'b0};
					lp_q <= lp_q - 5'd1;
				end
			end
			xfmix_pkg::ST_LSQ: begin
				lfrac_q <= frac_new;
				lb_q    <= lb_q - 4'd1;
				if (lb_q == '0 && !lsel_q) begin
					l1_q   <= {lp_q, frac_new};
					lm_q   <= 31'(it_q.len) + 31'd1;
					lp_q   <= xfmix_pkg::NORM_TOP;
					lsel_q <= 1'b1;
				end else begin
					// square the mantissa; crossing two yields the next fraction bit
					lm_q <= lsq_s[31] ? lsq_s[31:1] : lsq_s[30:0];
				end
			end
			xfmix_pkg::ST_CAP: begin
				pf_q <= 23'(fcap) * 23'(it_q.pct);
			end
			xfmix_pkg::ST_PDIV: begin
				f_q <= pf_prod[46:30];
			end
			xfmix_pkg::ST_BL1: begin
				acc_q <= a34 * wa34;
			end
			xfmix_pkg::ST_BL2: begin
				acc_q <= acc_q + b34 * wb34;
			end
			xfmix_pkg::ST_BL3: begin
				res_q <= acc_adj[31:16];
			end
			xfmix_pkg::ST_AVG: begin
				res_q <= neg_q ? -avg_prod[45:30] : avg_prod[45:30];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == xfmix_pkg::ST_DONE && out_free) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == xfmix_pkg::ST_DONE && out_free) begin
			omix_q <= res_q;
			osat_q <= sat_q;
		end
	end

	assign out_ch.valid        = ovalid_q;
	assign out_ch.mixed_sample = omix_q;
	assign out_ch.saturated    = osat_q;

endmodule

// ===== rtl/two_stream_audio_crossfade_mixer.sv =====
// ----------------------------------------------------------------------------
// two_stream_audio_crossfade_mixer
// Mixes two interleaved 16-bit sample streams with crossfade curves,
// average, additive or subtractive combining.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                             | handshake
//  in_ch    | in  | sample_a, sample_b, partner_present, start_of_clip | valid/ready
//  out_ch   | out | mixed_sample, saturated                             | valid/ready
//  config   | in  | wr_index, wr_data                                   | wr_en
//
//  one result per request; add/sub finish quickest, then average, then logarithmic,
//  exponential and sigmoid; the shared divider dominates the curves, which call
//  it up to 13 times (logarithmic once); percent scaling and the average use a
//  reciprocal multiply instead
//  the front and a two-deep queue keep taking requests while the back works
//  a finished result waits in the output register while the next one is computed
//  reset clears the position counters, the queue and the output register
// ----------------------------------------------------------------------------
module two_stream_audio_crossfade_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	xfmix_in_if.sink                             in_ch,
	xfmix_out_if.source                          out_ch,
	input  logic                                 wr_en,
	input  logic [xfmix_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [xfmix_pkg::CFG_DATA_BITS-1:0]  wr_data
);

	logic [xfmix_pkg::MODE_BITS-1:0] mode_q;
	logic [xfmix_pkg::PCT_BITS-1:0]  pct_q;
	logic [xfmix_pkg::CC_BITS-1:0]   cc_q;
	logic [xfmix_pkg::LEN_BITS-1:0]  len_q;

	logic                push_valid;
	logic                push_ready;
	xfmix_pkg::item_t    push_item;
	logic                pop_valid;
	logic                pop_ready;
	xfmix_pkg::item_t    pop_item;
	xfmix_pkg::div_req_t div_req;
	xfmix_pkg::div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= xfmix_pkg::MODE_EXP;
			pct_q  <= xfmix_pkg::PCT_RESET;
			cc_q   <= xfmix_pkg::CC_RESET;
			len_q  <= xfmix_pkg::LEN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				xfmix_pkg::REG_MIX_MODE:      mode_q <= wr_data[xfmix_pkg::MODE_BITS-1:0];
				xfmix_pkg::REG_MIX_PERCENT:   pct_q  <= wr_data[xfmix_pkg::PCT_BITS-1:0];
				xfmix_pkg::REG_CHANNEL_COUNT: cc_q   <= wr_data[xfmix_pkg::CC_BITS-1:0];
				xfmix_pkg::REG_TOTAL_FRAMES:  len_q  <= wr_data[xfmix_pkg::LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	xfmix_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.mix_mode      (mode_q),
		.mix_percent   (pct_q),
		.channel_count (cc_q),
		.total_frames  (len_q),
		.push_valid    (push_valid),
		.push_item     (push_item),
		.push_ready    (push_ready)
	);

	xfmix_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	xfmix_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	xfmix_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_ch    (out_ch)
	);

endmodule

// ===== rtl/xfmix_check.sv =====
// ----------------------------------------------------------------------------
// xfmix_check
// Port-level checks for the crossfade mixer, bound to the top level.
// ----------------------------------------------------------------------------
module xfmix_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] mixed_sample,
	input logic        saturated
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mixed_sample) && $stable(saturated))
		else $error("stalled result changed");

	// clipping only ever reports a rail value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> mixed_sample == 16'h7fff || mixed_sample == 16'h8000)
		else $error("saturated flag without rail value");

	// no result while in reset
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// the queue only fills through an accepted request
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("input stalled without a request");

endmodule

bind two_stream_audio_crossfade_mixer xfmix_check u_xfmix_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.mixed_sample (out_ch.mixed_sample),
	.saturated    (out_ch.saturated)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the crossfade mixer: random bursts of sample pairs
// over many register settings, each result checked against a cycle-free
// fixed-point model of the curves, average, add and subtract paths.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               present;
		logic               start;
	} pair_t;

	typedef struct {
		logic signed [15:0] sample;
		logic               sat;
	} mix_t;

	localparam int IDLE_LIMIT = 20000;
	localparam longint unsigned FMASK = (64'd1 << xfmix_pkg::FRAME_BITS) - 1;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [xfmix_pkg::CFG_IDX_BITS-1:0] wr_index;
	logic [xfmix_pkg::CFG_DATA_BITS-1:0] wr_data;

	xfmix_in_if  in_ch ();
	xfmix_out_if out_ch ();

	two_stream_audio_crossfade_mixer dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	pair_t pending[$];
	mix_t  expected[$];
	int    errors = 0;
	int    gap_left = 0;
	int    burst_left = 0;
	int    idle_cycles = 0;
	int    cyc = 0;

	// model copy of registers and position
	logic [2:0]  m_mode;
	logic [6:0]  m_pct;
	logic [3:0]  m_cc;
	logic [23:0] m_len;
	longint unsigned frame_pos;
	int unsigned chan_pos;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic longint unsigned exp_series(longint unsigned z, bit with_one);
		longint unsigned term, sum;
		term = z;
		sum = with_one ? (64'd1 << 30) + z : z;
		for (int k = 2; k <= 12; k++) begin
			term = ((term * z) >> 30) / k;
			sum += term;
		end
		return sum;
	endfunction

	function automatic longint unsigned log2_fix(longint unsigned v);
		int unsigned p;
		longint unsigned m, frac;
		p = 0;
		frac = 0;
		while (p < 63 && (v >> (p + 1)) != 0)
			p++;
		m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
		for (int b = 15; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m >>= 1;
				frac |= 64'd1 << b;
			end
		end
		return (longint'(p) << 16) | frac;
	endfunction

	function automatic longint unsigned blend_factor(logic [2:0] mode, longint unsigned i,
		longint unsigned n);
		longint unsigned x, f, tx, mid, u, e;
		x = (i << 16) / n;
		if (mode == xfmix_pkg::MODE_LOG) begin
			f = (log2_fix(i + 1) << 16) / log2_fix(n + 1);
		end else if (mode == xfmix_pkg::MODE_SIG) begin
			tx = 10 * x;
			mid = 5 * 64'd65536;
			u = (tx >= mid) ? tx - mid : mid - tx;
			e = exp_series(u << 11, 1'b1) >> 6;
			for (int s = 0; s < 3; s++)
				e = (e * e) >> 24;
			if (tx >= mid)
				f = (e << 16) / (e + (64'd1 << 24));
			else
				f = (64'd1 << 40) / (e + (64'd1 << 24));
		end else begin
			f = exp_series(x << 14, 1'b0) >> 14;
		end
		return (f > 65536) ? 64'd65536 : f;
	endfunction

	function automatic mix_t mix_predict(pair_t r);
		mix_t o;
		longint signed a, b, res;
		longint unsigned n, pct, i, f;
		int unsigned chans;
		a = r.a;
		b = r.b;
		n = (m_len == 0) ? 1 : m_len;
		pct = (m_pct > 100) ? 100 : m_pct;
		chans = m_cc;
		res = 0;
		o.sat = 1'b0;
		if (r.start) begin
			frame_pos = 0;
			chan_pos = 0;
		end
		if (chans < 1) chans = 1;
		if (chans > xfmix_pkg::MAX_CHANNELS) chans = xfmix_pkg::MAX_CHANNELS;
		if (m_mode == xfmix_pkg::MODE_AVG) begin
			res = (a * longint'(100 - pct) + b * longint'(pct)) / 100;
		end else if (m_mode == xfmix_pkg::MODE_ADD || m_mode == xfmix_pkg::MODE_SUB) begin
			res = (m_mode == xfmix_pkg::MODE_ADD) ? a + b : a - b;
			if (res > 32767) begin res = 32767; o.sat = 1'b1; end
			if (res < -32768) begin res = -32768; o.sat = 1'b1; end
		end else if (r.present) begin
			i = (frame_pos > n) ? n : frame_pos;
			f = blend_factor(m_mode, i, n);
			f = (f * pct) / 100;
			res = (a * longint'(65536 - f) + b * longint'(f)) / 65536;
		end
		o.sample = res[15:0];
		chan_pos++;
		if (chan_pos >= chans) begin
			chan_pos = 0;
			if (frame_pos < n && frame_pos < FMASK)
				frame_pos++;
		end
		return o;
	endfunction

	// driver: bursts of requests with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.sample_a <= '0;
			in_ch.sample_b <= '0;
			in_ch.partner_present <= 1'b0;
			in_ch.start_of_clip <= 1'b0;
		end else begin
			bit took;
			took = in_ch.valid && in_ch.ready;
			if (took) begin
				expected.push_back(mix_predict(pending.pop_front()));
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (!in_ch.valid || took) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.sample_a <= pending[0].a;
					in_ch.sample_b <= pending[0].b;
					in_ch.partner_present <= pending[0].present;
					in_ch.start_of_clip <= pending[0].start;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: free-running stretches alternate with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			if (cyc[10:9] == 2'd0)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected.size() == 0) begin
				$display("%0t: unexpected result sample=%0d sat=%0b", $time,
					out_ch.mixed_sample, out_ch.saturated);
				errors++;
			end else begin
				mix_t e;
				e = expected.pop_front();
				if (e.sample !== out_ch.mixed_sample) begin
					$display("%0t: mixed_sample expected %0d actual %0d", $time,
						e.sample, out_ch.mixed_sample);
					errors++;
				end
				if (e.sat !== out_ch.saturated) begin
					$display("%0t: saturated expected %0b actual %0b", $time,
						e.sat, out_ch.saturated);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without progress while work is outstanding
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(pending.size() == 0 && expected.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [xfmix_pkg::CFG_IDX_BITS-1:0] idx, logic [23:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			xfmix_pkg::REG_MIX_MODE:      m_mode = data[2:0];
			xfmix_pkg::REG_MIX_PERCENT:   m_pct = data[6:0];
			xfmix_pkg::REG_CHANNEL_COUNT: m_cc = data[3:0];
			xfmix_pkg::REG_TOTAL_FRAMES:  m_len = data;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_cfg(logic [2:0] mode, logic [6:0] pct, logic [3:0] cc, logic [23:0] n);
		write_reg(xfmix_pkg::REG_MIX_MODE, 24'(mode));
		write_reg(xfmix_pkg::REG_MIX_PERCENT, 24'(pct));
		write_reg(xfmix_pkg::REG_CHANNEL_COUNT, 24'(cc));
		write_reg(xfmix_pkg::REG_TOTAL_FRAMES, n);
	endtask

	task automatic add(int a, int b, bit p, bit s);
		pair_t r;
		r.a = a[15:0];
		r.b = b[15:0];
		r.present = p;
		r.start = s;
		pending.push_back(r);
	endtask

	task automatic drain();
		while (pending.size() != 0 || expected.size() != 0 || in_ch.valid)
			@(posedge clk);
	endtask

	function automatic int rand_sample();
		case ($urandom_range(0, 5))
			0: return 32767;
			1: return -32768;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	initial begin
		int n_items;
		logic [23:0] len;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		m_mode = xfmix_pkg::MODE_EXP;
		m_pct = xfmix_pkg::PCT_RESET;
		m_cc = xfmix_pkg::CC_RESET;
		m_len = xfmix_pkg::LEN_RESET;
		frame_pos = 0;
		chan_pos = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings
		add(1000, -1000, 1, 1); add(-32768, 32767, 1, 0);
		add(32767, -32768, 1, 0); add(5, 7, 0, 0);
		drain();
		set_cfg(xfmix_pkg::MODE_ADD, 7'd50, 4'd2, 24'd10);
		add(32767, 32767, 0, 1); add(-32768, -32768, 1, 0); add(0, 0, 0, 0);
		drain();
		set_cfg(xfmix_pkg::MODE_SUB, 7'd50, 4'd2, 24'd10);
		add(32767, -32768, 1, 0); add(-32768, 32767, 0, 0); add(-5, 3, 1, 0);
		drain();
		set_cfg(xfmix_pkg::MODE_AVG, 7'd0, 4'd2, 24'd10);
		add(-32768, 32767, 0, 0); add(-3, 4, 1, 0);
		drain();
		write_reg(xfmix_pkg::REG_MIX_PERCENT, 24'd127);
		add(-32768, 32767, 1, 0); add(-3, 4, 0, 0);
		drain();
		// clip length zero, channel count zero
		set_cfg(xfmix_pkg::MODE_EXP, 7'd100, 4'd0, 24'd0);
		add(-32768, 32767, 1, 1); add(100, -100, 0, 0); add(32767, -32768, 1, 0);
		drain();
		set_cfg(xfmix_pkg::MODE_LOG, 7'd100, 4'd1, 24'd4);
		for (int k = 0; k < 6; k++) add(-32768, 32767, 1, k == 0);
		drain();
		// channel count above the maximum, then clip shortened mid-clip
		set_cfg(xfmix_pkg::MODE_SIG, 7'd63, 4'd15, 24'd8);
		for (int k = 0; k < 20; k++) add(rand_sample(), rand_sample(), 1, k == 0);
		drain();
		write_reg(xfmix_pkg::REG_TOTAL_FRAMES, 24'd2);
		add(-32768, 32767, 1, 0); add(32767, -32768, 1, 0);
		drain();
		set_cfg(3'd7, 7'd100, 4'd8, 24'hFFFFFF);
		add(-32768, 32767, 1, 1); add(20000, -20000, 1, 0);
		drain();
		set_cfg(3'd6, 7'd1, 4'd1, 24'd3);
		add(-32768, 32767, 1, 1); add(1, 2, 1, 0);
		drain();

		n_items = 0;
		while (n_items < 400) begin
			int cnt;
			case ($urandom_range(0, 7))
				0: len = 24'hFFFFFF;
				1: len = 24'($urandom_range(0, 24'hFFFFFF));
				default: len = 24'($urandom_range(0, 40));
			endcase
			drain();
			set_cfg(3'($urandom_range(0, 7)),
				($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 7'd0 : 7'd100)
					: 7'($urandom_range(0, 127)),
				4'($urandom_range(0, 15)), len);
			cnt = $urandom_range(10, 50);
			for (int k = 0; k < cnt; k++)
				add(rand_sample(), rand_sample(), $urandom_range(0, 7) != 0,
					(k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 40) == 0));
			n_items += cnt;
		end
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
